@@ hw/rtl/kwt_pkg.sv @@
// shared constants and the symbol decode of the keyword trie lookup
package kwt_pkg;

	localparam int NODE_COUNT = 256;
	localparam int SYM_COUNT  = 27;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int FREE_W     = NODE_W + 1;
	localparam int SLOT_COUNT = NODE_COUNT * SYM_COUNT;
	localparam int SLOT_W     = $clog2(SLOT_COUNT);
	localparam int SYM_W      = $clog2(SYM_COUNT + 1);
	localparam int TYPE_W     = 4;
	localparam int MARK_W     = TYPE_W + 1;

	localparam logic [SYM_W-1:0] SYM_SKIP = SYM_W'(SYM_COUNT);
	localparam logic [SYM_W-1:0] SYM_UNDERSCORE = SYM_W'(26);

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	// folds upper case, maps a-z to 0..25 and '_' to 26, all else to the skip code
	function automatic logic [SYM_W-1:0] sym_of(input logic [7:0] c);
		logic [7:0] f;
		logic [7:0] d;
		f = c;
		if (c >= 8'd65 && c <= 8'd90) begin
			f = c + 8'd32;
		end
		d = f - 8'd97;
		if (f == 8'd95) begin
			return SYM_UNDERSCORE;
		end else if (f >= 8'd97 && f <= 8'd122) begin
			return d[SYM_W-1:0];
		end else begin
			return SYM_SKIP;
		end
	endfunction

endpackage

@@ hw/rtl/keyword_trie_lookup.sv @@
// keyword trie lookup: walks a child-link table one character per request
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | req_valid req_ready func char_code        | in
//          | word_end word_type                        |
//  result  | rsp_valid rsp_ready found found_type      | out
//          | pool_full was_insert                      |
//
// for each character the child link of the current node is first read from the
// link ram, then followed or allocated; a search word end adds an end-mark ram
// read of the final node
// after reset a clearing pass zeroes the link ram, one entry a cycle, over all
// NODE_COUNT*27 = 6912 entries; the mark ram is cleared in the same pass
// a word end waits while the result register still holds an untaken result;
// a character that ends no word never waits on the result side
module keyword_trie_lookup (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  logic                       func,
	input  logic [7:0]                 char_code,
	input  logic                       word_end,
	input  logic [3:0]                 word_type,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output logic                       found,
	output logic [3:0]                 found_type,
	output logic                       pool_full,
	output logic                       was_insert
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP,
		S_MARK
	} state_t;

	state_t state_q;

	// walk state
	logic [kwt_pkg::NODE_W-1:0] cur_node_q;
	logic [kwt_pkg::FREE_W-1:0] next_free_q;
	logic                       missed_q;
	logic                       ovf_q;
	logic [kwt_pkg::SLOT_W-1:0] clr_cnt_q;

	// request being worked on
	logic                        func_q;
	logic [kwt_pkg::SYM_W-1:0]   sym_q;
	logic                        last_q;
	logic [kwt_pkg::TYPE_W-1:0]  wtype_q;
	logic [kwt_pkg::SLOT_W-1:0]  slot_q;

	// result register
	logic                       rsp_valid_q;
	logic                       found_q;
	logic [kwt_pkg::TYPE_W-1:0] found_type_q;
	logic                       pool_full_q;
	logic                       was_insert_q;

	// ram ports
	logic                       link_we;
	logic [kwt_pkg::SLOT_W-1:0] link_waddr;
	logic [kwt_pkg::NODE_W-1:0] link_wdata;
	logic                       link_re;
	logic [kwt_pkg::SLOT_W-1:0] link_raddr;
	logic [kwt_pkg::NODE_W-1:0] link_rdata;
	logic                       mark_we;
	logic [kwt_pkg::NODE_W-1:0] mark_waddr;
	logic [kwt_pkg::MARK_W-1:0] mark_wdata;
	logic                       mark_re;
	logic [kwt_pkg::NODE_W-1:0] mark_raddr;
	logic [kwt_pkg::MARK_W-1:0] mark_rdata;

	logic                       req_fire;
	logic                       out_free;
	logic [kwt_pkg::SYM_W-1:0]  req_sym;
	logic                       req_sym_ok;
	logic                       walk;
	logic                       pool_left;
	logic [kwt_pkg::NODE_W-1:0] node_n;
	logic                       missed_n;
	logic                       ovf_n;
	logic                       alloc;
	logic                       clr_done;

	assign req_ready  = (state_q == S_IDLE);
	assign req_fire   = req_valid && req_ready;
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign req_sym    = kwt_pkg::sym_of(char_code);
	assign req_sym_ok = (req_sym != kwt_pkg::SYM_SKIP);
	assign clr_done   = (clr_cnt_q == kwt_pkg::SLOT_W'(kwt_pkg::SLOT_COUNT - 1));
	assign pool_left  = !next_free_q[kwt_pkg::NODE_W];

	// slot of the child link: node * 27 + symbol
	assign link_raddr = kwt_pkg::SLOT_W'(cur_node_q) * kwt_pkg::SLOT_W'(kwt_pkg::SYM_COUNT)
		+ kwt_pkg::SLOT_W'(req_sym);
	assign link_re    = req_fire && req_sym_ok;

	// one step of the walk, valid while in S_LOOKUP
	always_comb begin
		walk     = (sym_q != kwt_pkg::SYM_SKIP) && !missed_q && !ovf_q;
		node_n   = cur_node_q;
		missed_n = missed_q;
		ovf_n    = ovf_q;
		alloc    = 1'b0;
		if (walk) begin
			if (link_rdata != '0) begin
				node_n = link_rdata;
			end else if (func_q == kwt_pkg::FUNC_SEARCH) begin
				missed_n = 1'b1;
			end else if (pool_left) begin
				alloc  = 1'b1;
				node_n = next_free_q[kwt_pkg::NODE_W-1:0];
			end else begin
				ovf_n = 1'b1;
			end
		end
	end

	// a word-ending insert holds in S_LOOKUP until the result register frees
	logic lookup_go;
	assign lookup_go = !(last_q && func_q == kwt_pkg::FUNC_INSERT) || out_free;

	// result register loads on an insert word end or a returned end mark
	logic rsp_load;
	assign rsp_load = (state_q == S_LOOKUP && lookup_go && last_q
		&& func_q == kwt_pkg::FUNC_INSERT) || (state_q == S_MARK && out_free);

	always_comb begin
		link_we    = 1'b0;
		link_waddr = slot_q;
		link_wdata = next_free_q[kwt_pkg::NODE_W-1:0];
		mark_we    = 1'b0;
		mark_waddr = node_n;
		mark_wdata = {1'b1, wtype_q};
		mark_re    = 1'b0;
		mark_raddr = node_n;
		unique case (state_q)
			S_CLEAR: begin
				link_we    = 1'b1;
				link_waddr = clr_cnt_q;
				link_wdata = '0;
				mark_we    = (clr_cnt_q < kwt_pkg::SLOT_W'(kwt_pkg::NODE_COUNT));
				mark_waddr = clr_cnt_q[kwt_pkg::NODE_W-1:0];
				mark_wdata = '0;
			end
			S_LOOKUP: begin
				if (lookup_go) begin
					link_we = alloc;
					if (last_q && func_q == kwt_pkg::FUNC_INSERT) begin
						mark_we = !missed_n && !ovf_n;
					end
					if (last_q && func_q == kwt_pkg::FUNC_SEARCH) begin
						mark_re = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_cnt_q   <= '0;
			cur_node_q  <= '0;
			next_free_q <= kwt_pkg::FREE_W'(1);
			missed_q    <= 1'b0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						func_q  <= func;
						sym_q   <= req_sym;
						last_q  <= word_end;
						wtype_q <= word_type;
						slot_q  <= link_raddr;
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					if (lookup_go) begin
						if (alloc) begin
							next_free_q <= next_free_q + 1'b1;
						end
						if (!last_q) begin
							// mid-word: keep walking from the new node
							cur_node_q <= node_n;
							missed_q   <= missed_n;
							ovf_q      <= ovf_n;
							state_q    <= S_IDLE;
						end else if (func_q == kwt_pkg::FUNC_SEARCH) begin
							// end mark of the final node comes back next cycle
							missed_q <= missed_n;
							state_q  <= S_MARK;
						end else begin
							found_q      <= 1'b0;
							found_type_q <= '0;
							pool_full_q  <= ovf_n;
							was_insert_q <= 1'b1;
							cur_node_q   <= '0;
							missed_q     <= 1'b0;
							ovf_q        <= 1'b0;
							state_q      <= S_IDLE;
						end
					end
				end
				S_MARK: begin
					if (out_free) begin
						found_q      <= !missed_q && mark_rdata[kwt_pkg::TYPE_W];
						found_type_q <= (!missed_q && mark_rdata[kwt_pkg::TYPE_W])
							? mark_rdata[kwt_pkg::TYPE_W-1:0] : '0;
						pool_full_q  <= 1'b0;
						was_insert_q <= 1'b0;
						cur_node_q   <= '0;
						missed_q     <= 1'b0;
						ovf_q        <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// child links, one entry per node and symbol
	kwt_ram #(
		.WIDTH(kwt_pkg::NODE_W),
		.DEPTH(kwt_pkg::SLOT_COUNT)
	) u_link_ram (
		.clk    (clk),
		.wr_en  (link_we),
		.wr_addr(link_waddr),
		.wr_data(link_wdata),
		.rd_en  (link_re),
		.rd_addr(link_raddr),
		.rd_data(link_rdata)
	);

	// end mark and keyword type per node
	kwt_ram #(
		.WIDTH(kwt_pkg::MARK_W),
		.DEPTH(kwt_pkg::NODE_COUNT)
	) u_mark_ram (
		.clk    (clk),
		.wr_en  (mark_we),
		.wr_addr(mark_waddr),
		.wr_data(mark_wdata),
		.rd_en  (mark_re),
		.rd_addr(mark_raddr),
		.rd_data(mark_rdata)
	);

	assign rsp_valid  = rsp_valid_q;
	assign found      = found_q;
	assign found_type = found_type_q;
	assign pool_full  = pool_full_q;
	assign was_insert = was_insert_q;

	// the walk never stands on a node that has not been handed out
	a_cur_allocated: assert property (@(posedge clk) disable iff (!arst_n)
		kwt_pkg::FREE_W'(cur_node_q) < next_free_q)
		else $error("current node beyond allocated pool");

	// the pool pointer never passes the node count
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= kwt_pkg::FREE_W'(kwt_pkg::NODE_COUNT))
		else $error("next free pointer past node count");

	// a link is only written over an empty slot outside the clearing pass
	a_link_empty: assert property (@(posedge clk) disable iff (!arst_n)
		link_we && state_q == S_LOOKUP |-> link_rdata == '0)
		else $error("allocation over an existing child link");

	// inserts never report a hit, searches never report pool exhaustion
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (was_insert_q ? (!found_q && found_type_q == '0) : !pool_full_q))
		else $error("result fields inconsistent with its kind");

	// no request is taken while the clearing pass runs
	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR && !clr_done |=> !rsp_valid_q && next_free_q == kwt_pkg::FREE_W'(1))
		else $error("activity during clearing pass");

endmodule

@@ hw/rtl/kwt_ram.sv @@
// generic single-write, single-read ram with registered read data
module kwt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
